FILE: rtl/core/afsd_pkg.sv
// Shared types and constants for the accelerometer FIFO sample deframer.
// No dependencies; imported by afsd_group and accel_fifo_sample_deframer.
`default_nettype none

package afsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned VAL_W  = 14;
	localparam int unsigned TAG_W  = 2;

	// Tag carried in bits 15:14 of the x word.
	localparam logic [TAG_W-1:0] TAG_X = 2'd0;

	// Position of the next word within the sample group.
	typedef enum logic [1:0] {
		WIDX_X = 2'd0,
		WIDX_Y = 2'd1,
		WIDX_Z = 2'd2,
		WIDX_T = 2'd3
	} afsd_widx_t;

	typedef logic [BYTE_W-1:0]       afsd_byte_t;
	typedef logic signed [VAL_W-1:0] afsd_val_t;

	// One completed sample, valid for the cycle in which emit is high.
	typedef struct packed {
		logic      emit;
		afsd_val_t x;
		afsd_val_t y;
		afsd_val_t z;
		afsd_val_t t;
	} afsd_sample_t;

endpackage

`default_nettype wire

FILE: rtl/core/afsd_group.sv
// Byte pairing, x-tag alignment and sample grouping for the deframer.
// Depends on afsd_pkg.
`default_nettype none

module afsd_group import afsd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire afsd_byte_t   byte_in,
	input  wire logic         temp_stored,
	output afsd_sample_t      sample
);

	logic        phase_q;
	logic        aligned_q;
	logic        aligned_d;
	afsd_widx_t  widx_q;
	afsd_widx_t  widx_d;
	afsd_byte_t  low_q;
	afsd_val_t   x_q;
	afsd_val_t   y_q;
	afsd_val_t   z_q;

	logic             word_done;
	logic [TAG_W-1:0] tag;
	afsd_val_t        val;

	assign word_done = step && phase_q;
	assign tag       = byte_in[BYTE_W-1 -: TAG_W];
	assign val       = afsd_val_t'({byte_in[BYTE_W-TAG_W-1:0], low_q});

	// Next state.
	always_comb begin
		widx_d    = widx_q;
		aligned_d = aligned_q;
		if (word_done) begin
			if (!aligned_q) begin
				if (tag == TAG_X) begin
					aligned_d = 1'b1;
					widx_d    = WIDX_Y;
				end
			end else begin
				unique case (widx_q)
					WIDX_X: widx_d = WIDX_Y;
					WIDX_Y: widx_d = WIDX_Z;
					WIDX_Z: widx_d = temp_stored ? WIDX_T : WIDX_X;
					WIDX_T: widx_d = WIDX_X;
					default: widx_d = WIDX_X;
				endcase
			end
		end
	end

	// Outputs.
	always_comb begin
		sample.emit = word_done && aligned_q &&
			((widx_q == WIDX_Z && !temp_stored) || widx_q == WIDX_T);
		sample.x = x_q;
		sample.y = y_q;
		sample.z = (widx_q == WIDX_Z) ? val : z_q;
		sample.t = (widx_q == WIDX_T) ? val : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			aligned_q <= 1'b0;
			widx_q    <= WIDX_X;
		end else begin
			if (step) begin
				phase_q <= !phase_q;
			end
			aligned_q <= aligned_d;
			widx_q    <= widx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !phase_q) begin
			low_q <= byte_in;
		end
		if (word_done) begin
			if (!aligned_q) begin
				if (tag == TAG_X) begin
					x_q <= val;
				end
			end else begin
				unique case (widx_q)
					WIDX_X: x_q <= val;
					WIDX_Y: y_q <= val;
					WIDX_Z: z_q <= val;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/accel_fifo_sample_deframer.sv
// Accelerometer FIFO sample deframer: one byte per cycle in, one x/y/z/temp sample out.
// Path: the last byte of a sample goes via the input register to the output register;
// it waits in the input register while a previous sample is still waiting to be taken.
// Throughput: one byte per cycle unless the output stalls; the input register and the
// output register let a new byte enter while a finished sample waits to be taken.
// Reset (arst_n low, asynchronous) clears alignment, byte phase and temp_stored.
// Depends on afsd_pkg and afsd_group.
`default_nettype none

module accel_fifo_sample_deframer import afsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire afsd_byte_t fifo_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output afsd_val_t       accel_x,
	output afsd_val_t       accel_y,
	output afsd_val_t       accel_z,
	output afsd_val_t       temp_value
);

	logic         temp_stored_q;
	logic         valid_s1;
	afsd_byte_t   byte_s1;
	logic         advance;
	logic         out_valid_q;
	afsd_sample_t sample;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	afsd_group u_group (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.byte_in     (byte_s1),
		.temp_stored (temp_stored_q),
		.sample      (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_stored_q <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				temp_stored_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && sample.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= fifo_byte;
		end
		if (advance && sample.emit) begin
			accel_x    <= sample.x;
			accel_y    <= sample.y;
			accel_z    <= sample.z;
			temp_value <= sample.t;
		end
	end

	// An empty input stage must never hold off the upstream side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// An accepted byte always lands in the input stage.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte lost before the input stage");

	// A completed sample is presented on the next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && sample.emit |=> out_valid)
		else $error("completed sample not presented");

	// The input stage only advances into a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
